### hdl/qvr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qvr_pkg
// Word types, widths and the output rounding/saturation helper shared by the
// quaternion vector rotation block.
// ---------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned P_WIDTH    = DATA_WIDTH + 4;

  // Product and sum widths of both multiply passes.
  localparam int unsigned M1_WIDTH = 2 * DATA_WIDTH;
  localparam int unsigned S1_WIDTH = M1_WIDTH + 2;
  localparam int unsigned M2_WIDTH = DATA_WIDTH + P_WIDTH;
  localparam int unsigned S2_WIDTH = M2_WIDTH + 2;
  localparam int unsigned R2_WIDTH = S2_WIDTH - FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [P_WIDTH-1:0]    pval_t;

  typedef struct packed {
    data_t q_x;
    data_t q_y;
    data_t q_z;
    data_t q_w;
    data_t v_x;
    data_t v_y;
    data_t v_z;
  } qvr_in_t;

  typedef struct packed {
    data_t r_x;
    data_t r_y;
    data_t r_z;
    logic  clipped;
  } qvr_out_t;

  typedef struct packed {
    data_t value;
    logic  hit;
  } sat_t;

  // Half-up rounding (add half an LSB, then floor) followed by saturation
  // to the data width.
  function automatic sat_t round_sat(logic signed [S2_WIDTH-1:0] sum);
    logic signed [S2_WIDTH-1:0] biased;
    logic signed [R2_WIDTH-1:0] rnd;
    logic signed [R2_WIDTH-1:0] hi_lim;
    logic signed [R2_WIDTH-1:0] lo_lim;
    sat_t res;
    biased = sum + (S2_WIDTH'(1) <<< (FRAC_BITS - 1));
    rnd    = biased[S2_WIDTH-1:FRAC_BITS];
    hi_lim = R2_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    lo_lim = -hi_lim - R2_WIDTH'(1);
    if (rnd > hi_lim) begin
      res.value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      res.hit   = 1'b1;
    end else if (rnd < lo_lim) begin
      res.value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      res.hit   = 1'b1;
    end else begin
      res.value = rnd[DATA_WIDTH-1:0];
      res.hit   = 1'b0;
    end
    return res;
  endfunction

endpackage

### hdl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a Q2.14 quaternion as q*(v,0)*conj(q) in fixed point.
// ---------------------------------------------------------------------------
// A word is taken whenever start_i is high; busy_o is always low, so one word
// can enter every cycle. Each result appears on res_o for one cycle with
// done_o high, in input order. The receiver cannot stall the block and must
// take every result as it comes. The four stages are: first-pass multiplies,
// first-pass sums with rounding, second-pass multiplies, and second-pass sums
// with rounding and saturation. The quaternion is not normalized, so a
// non-unit q scales the result by |q|^2; clipped is set when any output
// component saturates.
module quaternion_vector_rotate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  qvr_pkg::qvr_in_t  in_i,
  output logic              done_o,
  output qvr_pkg::qvr_out_t res_o
);

  localparam int unsigned NPROD = 12;

  // Stage 1: first-pass products.
  logic                                  v1_q;
  logic signed [qvr_pkg::M1_WIDTH-1:0]   m1_q [NPROD];
  logic signed [qvr_pkg::M1_WIDTH-1:0]   m1_d [NPROD];
  qvr_pkg::data_t                        qx1_q, qy1_q, qz1_q, qw1_q;

  // Stage 2: rounded intermediate p.
  logic                                  v2_q;
  qvr_pkg::pval_t                        px_q, py_q, pz_q, pw_q;
  qvr_pkg::pval_t                        px_d, py_d, pz_d, pw_d;
  qvr_pkg::data_t                        qx2_q, qy2_q, qz2_q, qw2_q;

  // Stage 3: second-pass products.
  logic                                  v3_q;
  logic signed [qvr_pkg::M2_WIDTH-1:0]   m2_q [NPROD];
  logic signed [qvr_pkg::M2_WIDTH-1:0]   m2_d [NPROD];

  // Stage 4: output register.
  logic                                  v4_q;
  qvr_pkg::qvr_out_t                     res_q, res_d;

  assign busy_o = 1'b0;

  // p = (v,0) * conj(q): p.xyz = qw*v - v x qv, p.w = v . qv
  always_comb begin
    m1_d[0]  = in_i.q_w * in_i.v_x;
    m1_d[1]  = in_i.v_y * in_i.q_z;
    m1_d[2]  = in_i.v_z * in_i.q_y;
    m1_d[3]  = in_i.q_w * in_i.v_y;
    m1_d[4]  = in_i.v_z * in_i.q_x;
    m1_d[5]  = in_i.v_x * in_i.q_z;
    m1_d[6]  = in_i.q_w * in_i.v_z;
    m1_d[7]  = in_i.v_x * in_i.q_y;
    m1_d[8]  = in_i.v_y * in_i.q_x;
    m1_d[9]  = in_i.v_x * in_i.q_x;
    m1_d[10] = in_i.v_y * in_i.q_y;
    m1_d[11] = in_i.v_z * in_i.q_z;
  end

  // First-pass sums, rounded half-up. The sums are at most 3*2^30 in
  // magnitude, so the rounded values always fit the intermediate width and
  // p is taken from the rounded sums with no clamp.
  always_comb begin
    logic signed [qvr_pkg::S1_WIDTH-1:0] sx, sy, sz, sw;
    logic signed [qvr_pkg::S1_WIDTH-1:0] half;
    half = qvr_pkg::S1_WIDTH'(1) <<< (qvr_pkg::FRAC_BITS - 1);
    sx = qvr_pkg::S1_WIDTH'(m1_q[0]) - qvr_pkg::S1_WIDTH'(m1_q[1])
       + qvr_pkg::S1_WIDTH'(m1_q[2]) + half;
    sy = qvr_pkg::S1_WIDTH'(m1_q[3]) - qvr_pkg::S1_WIDTH'(m1_q[4])
       + qvr_pkg::S1_WIDTH'(m1_q[5]) + half;
    sz = qvr_pkg::S1_WIDTH'(m1_q[6]) - qvr_pkg::S1_WIDTH'(m1_q[7])
       + qvr_pkg::S1_WIDTH'(m1_q[8]) + half;
    sw = qvr_pkg::S1_WIDTH'(m1_q[9]) + qvr_pkg::S1_WIDTH'(m1_q[10])
       + qvr_pkg::S1_WIDTH'(m1_q[11]) + half;
    px_d = sx[qvr_pkg::S1_WIDTH-1:qvr_pkg::FRAC_BITS];
    py_d = sy[qvr_pkg::S1_WIDTH-1:qvr_pkg::FRAC_BITS];
    pz_d = sz[qvr_pkg::S1_WIDTH-1:qvr_pkg::FRAC_BITS];
    pw_d = sw[qvr_pkg::S1_WIDTH-1:qvr_pkg::FRAC_BITS];
  end

  // r = q * p, vector part: qv x pv + pw*qv + qw*pv
  always_comb begin
    m2_d[0]  = qy2_q * pz_q;
    m2_d[1]  = qz2_q * py_q;
    m2_d[2]  = pw_q  * qx2_q;
    m2_d[3]  = qw2_q * px_q;
    m2_d[4]  = qz2_q * px_q;
    m2_d[5]  = qx2_q * pz_q;
    m2_d[6]  = pw_q  * qy2_q;
    m2_d[7]  = qw2_q * py_q;
    m2_d[8]  = qx2_q * py_q;
    m2_d[9]  = qy2_q * px_q;
    m2_d[10] = pw_q  * qz2_q;
    m2_d[11] = qw2_q * pz_q;
  end

  always_comb begin
    logic signed [qvr_pkg::S2_WIDTH-1:0] sx, sy, sz;
    qvr_pkg::sat_t                       rx, ry, rz;
    sx = qvr_pkg::S2_WIDTH'(m2_q[0]) - qvr_pkg::S2_WIDTH'(m2_q[1])
       + qvr_pkg::S2_WIDTH'(m2_q[2]) + qvr_pkg::S2_WIDTH'(m2_q[3]);
    sy = qvr_pkg::S2_WIDTH'(m2_q[4]) - qvr_pkg::S2_WIDTH'(m2_q[5])
       + qvr_pkg::S2_WIDTH'(m2_q[6]) + qvr_pkg::S2_WIDTH'(m2_q[7]);
    sz = qvr_pkg::S2_WIDTH'(m2_q[8]) - qvr_pkg::S2_WIDTH'(m2_q[9])
       + qvr_pkg::S2_WIDTH'(m2_q[10]) + qvr_pkg::S2_WIDTH'(m2_q[11]);
    rx = qvr_pkg::round_sat(sx);
    ry = qvr_pkg::round_sat(sy);
    rz = qvr_pkg::round_sat(sz);
    res_d.r_x     = rx.value;
    res_d.r_y     = ry.value;
    res_d.r_z     = rz.value;
    res_d.clipped = rx.hit | ry.hit | rz.hit;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Data registers, loaded only when their stage takes a word.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m1_q  <= m1_d;
      qx1_q <= in_i.q_x;
      qy1_q <= in_i.q_y;
      qz1_q <= in_i.q_z;
      qw1_q <= in_i.q_w;
    end
    if (v1_q) begin
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      pw_q  <= pw_d;
      qx2_q <= qx1_q;
      qy2_q <= qy1_q;
      qz2_q <= qz1_q;
      qw2_q <= qw1_q;
    end
    if (v2_q) begin
      m2_q <= m2_d;
    end
    if (v3_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = v4_q;
  assign res_o  = res_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_vector_rotate. Words go in through the
// start/busy handshake, and a local fixed-point model of the two-pass
// rotation predicts each result. A checker compares every done_o word,
// field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned Q_ONE = 1 << qvr_pkg::FRAC_BITS;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  qvr_pkg::qvr_in_t  in_i;
  logic              done_o;
  qvr_pkg::qvr_out_t res_o;

  qvr_pkg::qvr_out_t pending_rotations[$];
  int                mismatch_count;
  bit                gaps_on;

  quaternion_vector_rotate uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Half-up rounding: add half an LSB, then floor through the arithmetic shift.
  function automatic longint round_half_up(longint x);
    return (x + (longint'(1) <<< (qvr_pkg::FRAC_BITS - 1))) >>> qvr_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp_signed(longint x, int w, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic qvr_pkg::qvr_out_t rotate_vector(qvr_pkg::qvr_in_t w);
    longint qx, qy, qz, qw, vx, vy, vz;
    longint px, py, pz, pw, rx, ry, rz;
    bit p_hit;
    bit r_hit;
    qvr_pkg::qvr_out_t r;
    qx = longint'(w.q_x);
    qy = longint'(w.q_y);
    qz = longint'(w.q_z);
    qw = longint'(w.q_w);
    vx = longint'(w.v_x);
    vy = longint'(w.v_y);
    vz = longint'(w.v_z);
    p_hit = 1'b0;
    r_hit = 1'b0;
    // First pass: p = (v,0) * conj(q).
    px = qw * vx - (vy * qz - vz * qy);
    py = qw * vy - (vz * qx - vx * qz);
    pz = qw * vz - (vx * qy - vy * qx);
    pw = vx * qx + vy * qy + vz * qz;
    px = clamp_signed(round_half_up(px), int'(qvr_pkg::P_WIDTH), p_hit);
    py = clamp_signed(round_half_up(py), int'(qvr_pkg::P_WIDTH), p_hit);
    pz = clamp_signed(round_half_up(pz), int'(qvr_pkg::P_WIDTH), p_hit);
    pw = clamp_signed(round_half_up(pw), int'(qvr_pkg::P_WIDTH), p_hit);
    // Second pass: vector part of q * p. A clamp in the first pass never sets clipped.
    rx = (qy * pz - qz * py) + pw * qx + qw * px;
    ry = (qz * px - qx * pz) + pw * qy + qw * py;
    rz = (qx * py - qy * px) + pw * qz + qw * pz;
    r.r_x = qvr_pkg::data_t'(clamp_signed(round_half_up(rx),
                                          int'(qvr_pkg::DATA_WIDTH), r_hit));
    r.r_y = qvr_pkg::data_t'(clamp_signed(round_half_up(ry),
                                          int'(qvr_pkg::DATA_WIDTH), r_hit));
    r.r_z = qvr_pkg::data_t'(clamp_signed(round_half_up(rz),
                                          int'(qvr_pkg::DATA_WIDTH), r_hit));
    r.clipped = r_hit;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Checker. Outputs are sampled at the edge that ends the done_o cycle.
  always @(posedge clk_i) begin
    qvr_pkg::qvr_out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rotations.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res_o));
      end else begin
        want = pending_rotations.pop_front();
        if (res_o.r_x !== want.r_x)
          report_mismatch($sformatf("r_x got %0d want %0d", res_o.r_x, want.r_x));
        if (res_o.r_y !== want.r_y)
          report_mismatch($sformatf("r_y got %0d want %0d", res_o.r_y, want.r_y));
        if (res_o.r_z !== want.r_z)
          report_mismatch($sformatf("r_z got %0d want %0d", res_o.r_z, want.r_z));
        if (res_o.clipped !== want.clipped)
          report_mismatch($sformatf("clipped got %b want %b", res_o.clipped,
                                    want.clipped));
      end
    end
  end

  // Holds start_i high until the word is taken, then maybe leaves a gap.
  task automatic send_word(qvr_pkg::qvr_in_t w);
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_rotations.push_back(rotate_vector(w));
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic qvr_pkg::qvr_in_t make_word(int qx, int qy, int qz, int qw,
                                                 int vx, int vy, int vz);
    qvr_pkg::qvr_in_t w;
    w.q_x = qvr_pkg::data_t'(qx);
    w.q_y = qvr_pkg::data_t'(qy);
    w.q_z = qvr_pkg::data_t'(qz);
    w.q_w = qvr_pkg::data_t'(qw);
    w.v_x = qvr_pkg::data_t'(vx);
    w.v_y = qvr_pkg::data_t'(vy);
    w.v_z = qvr_pkg::data_t'(vz);
    return w;
  endfunction

  function automatic qvr_pkg::data_t random_data();
    return qvr_pkg::data_t'($urandom_range(0, 65535));
  endfunction

  task automatic test_directed();
    int q;
    q = Q_ONE;
    // Identity and negated identity with extreme vectors.
    send_word(make_word(0, 0, 0, q, 32767, -32768, 1));
    send_word(make_word(0, 0, 0, -q, -32768, 32767, -1));
    // Zero quaternion gives zero with no clipping.
    send_word(make_word(0, 0, 0, 0, 32767, 32767, -32768));
    // Quarter turns about z, x and y (cos 45 = 11585 in Q2.14).
    send_word(make_word(0, 0, 11585, 11585, 1000, 0, 0));
    send_word(make_word(11585, 0, 0, 11585, 0, 32767, -32768));
    send_word(make_word(0, 11585, 0, -11585, -32768, 0, 32767));
    // Half turn about x.
    send_word(make_word(q, 0, 0, 0, 12345, -2345, 345));
    // Rounding ties, positive and negative, through a half-scale quaternion.
    send_word(make_word(0, 0, 0, q / 2, 1, -1, 3));
    send_word(make_word(0, 0, 0, q / 2, -3, 5, -5));
    send_word(make_word(q / 2, q / 2, q / 2, q / 2, 1, -1, 1));
    // Extreme quaternions, both signs, scale nonzero vectors far past the range.
    send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_word(make_word(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_word(make_word(-32768, 0, 0, 0, 20000, -20000, 100));
    send_word(make_word(0, 0, 0, 32767, 0, 0, 0));
    send_word(make_word(0, 0, 0, -32768, 16383, -16384, 0));
  endtask

  // Near-unit quaternions with random axes; some are scaled up a little so
  // that the |q|^2 gain pushes large vectors into saturation.
  task automatic test_unit_rotations(int count);
    real c[4];
    real norm;
    real gain;
    qvr_pkg::qvr_in_t w;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 4; k++)
        c[k] = (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      if (norm < 0.01) begin
        c[0] = 0.0; c[1] = 0.0; c[2] = 0.0; c[3] = 1.0;
        norm = 1.0;
      end
      gain = ($urandom_range(0, 3) == 0) ? 1.0 + real'($urandom_range(0, 200)) / 1000.0
                                         : 1.0;
      w.q_x = qvr_pkg::data_t'($rtoi(c[0] / norm * gain * Q_ONE));
      w.q_y = qvr_pkg::data_t'($rtoi(c[1] / norm * gain * Q_ONE));
      w.q_z = qvr_pkg::data_t'($rtoi(c[2] / norm * gain * Q_ONE));
      w.q_w = qvr_pkg::data_t'($rtoi(c[3] / norm * gain * Q_ONE));
      if ($urandom_range(0, 1) == 0) begin
        w.v_x = random_data();
        w.v_y = random_data();
        w.v_z = random_data();
      end else begin
        w.v_x = qvr_pkg::data_t'($urandom_range(0, 2000)) - qvr_pkg::data_t'(1000);
        w.v_y = qvr_pkg::data_t'($urandom_range(0, 2000)) - qvr_pkg::data_t'(1000);
        w.v_z = qvr_pkg::data_t'($urandom_range(0, 2000)) - qvr_pkg::data_t'(1000);
      end
      send_word(w);
    end
  endtask

  // Unconstrained bit patterns in every field.
  task automatic test_raw_words(int count);
    qvr_pkg::qvr_in_t w;
    for (int i = 0; i < count; i++) begin
      w.q_x = random_data();
      w.q_y = random_data();
      w.q_z = random_data();
      w.q_w = random_data();
      w.v_x = random_data();
      w.v_y = random_data();
      w.v_z = random_data();
      send_word(w);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    in_i           = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_unit_rotations(450);
    test_raw_words(280);
    // Final stretch runs back to back with no gaps.
    gaps_on = 1'b0;
    test_unit_rotations(60);
    test_raw_words(50);
    start_i <= 1'b0;

    while (pending_rotations.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("tb: errors");
    $finish;
  end

endmodule
